>>> rtl/keyword_identifier_tokenizer_top_defines.svh
// ---------------------------------------------------------------------------
// keyword_identifier_tokenizer_top_defines.svh
// assertion macros used by the tokenizer back end (kit_back)
// ---------------------------------------------------------------------------
`ifndef KEYWORD_IDENTIFIER_TOKENIZER_TOP_DEFINES_SVH
`define KEYWORD_IDENTIFIER_TOKENIZER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define KIT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// next-cycle implication, disabled while reset is held
`define KIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

>>> rtl/kit_pkg.sv
// ---------------------------------------------------------------------------
// kit_pkg
// types, constants and keyword helpers of the keyword/identifier tokenizer
// ---------------------------------------------------------------------------
package kit_pkg;

    localparam int MAX_NAME      = 512;
    localparam int MAX_FILE_NAME = 64;
    localparam int LINE_BITS     = 20;

    localparam int LEN_W  = $clog2(MAX_NAME + 1);
    localparam int FCNT_W = $clog2(MAX_FILE_NAME + 1);

    // queue depths, powers of two so pointers wrap on their own
    localparam int FQ_DEPTH = 2;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);

    // output payload: value, line, length, zero padded to bytes
    localparam int OUT_BITS = 8 + LINE_BITS + LEN_W;
    localparam int TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD  = TDATA_W - OUT_BITS;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;

    typedef enum logic [2:0] {
        M_START,
        M_IDENT,
        M_IDENT_NUL,
        M_HASH_SP,
        M_HASH_DIG,
        M_SEEK_Q,
        M_FNAME,
        M_SKIP_EOL
    } t_mode;

    typedef enum logic [3:0] {
        K_END,
        K_CHAR,
        K_NAME_BYTE,
        K_NAME,
        K_INORDER,
        K_OUTORDER,
        K_PLANAME,
        K_ONE,
        K_ZERO
    } t_kind;

    // one input byte with its character classes
    typedef struct packed {
        logic [7:0] data;
        logic       eof;
        logic       blank;
        logic       newline;
        logic       hash;
        logic       quote;
        logic       space;
        logic       digit;
        logic       id_start;
        logic       id_cont;
    } t_item;

    typedef struct packed {
        t_kind                kind;
        logic [7:0]           value;
        logic [LINE_BITS-1:0] line;
        logic [LEN_W-1:0]     len;
        logic                 last;
    } t_result;

    // up to two results written into the result queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    localparam int NKW      = 5;
    localparam int KW_SLOTS = 8;
    localparam int KW_IW    = $clog2(KW_SLOTS);
    localparam logic [NKW-1:0] ALL_KW = {NKW{1'b1}};

    localparam logic [LEN_W-1:0] KW_LEN [NKW] = '{
        LEN_W'(7), LEN_W'(8), LEN_W'(4), LEN_W'(3), LEN_W'(4)
    };

    localparam logic [7:0] KW_TEXT [NKW][KW_SLOTS] = '{
        '{"I", "N", "O", "R", "D", "E", "R", CH_NUL},
        '{"O", "U", "T", "O", "R", "D", "E", "R"},
        '{"N", "A", "M", "E", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"O", "N", "E", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"Z", "E", "R", "O", CH_NUL, CH_NUL, CH_NUL, CH_NUL}
    };

    // drop keywords whose byte at this position differs
    function automatic logic [NKW-1:0] kw_narrow(input logic [NKW-1:0] cand,
                                                 input logic [LEN_W-1:0] pos,
                                                 input logic [7:0] b);
        logic [NKW-1:0] keep;
        for (int k = 0; k < NKW; k++) begin
            keep[k] = cand[k] && (pos < KW_LEN[k]) && (KW_TEXT[k][pos[KW_IW-1:0]] == b);
        end
        return keep;
    endfunction

    // keep only keywords as long as the name up to its first nul
    function automatic logic [NKW-1:0] kw_trim(input logic [NKW-1:0] cand,
                                               input logic [LEN_W-1:0] len);
        logic [NKW-1:0] keep;
        for (int k = 0; k < NKW; k++) begin
            keep[k] = cand[k] && (KW_LEN[k] == len);
        end
        return keep;
    endfunction

    // kind of a finished name, first matching keyword wins
    function automatic t_kind kw_finish(input logic [NKW-1:0] cand,
                                        input logic [LEN_W-1:0] len,
                                        input logic nul_seen);
        t_kind kind;
        kind = K_NAME;
        for (int k = NKW - 1; k >= 0; k--) begin
            if (cand[k] && (nul_seen || (KW_LEN[k] == len))) begin
                kind = t_kind'(4'(int'(K_INORDER) + k));
            end
        end
        return kind;
    endfunction

endpackage

>>> rtl/kit_front.sv
// ---------------------------------------------------------------------------
// kit_front
// input side: classifies each byte and holds it in a two-entry queue
// ---------------------------------------------------------------------------
module kit_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    input  logic [7:0]     i_s_axis_tdata,   // data_byte
    input  logic           i_s_axis_tuser,   // end_of_input
    output logic           o_q_valid,
    output kit_pkg::t_item o_q_item,
    input  logic           i_q_pop
);

    kit_pkg::t_item r_slot [kit_pkg::FQ_DEPTH];
    logic [kit_pkg::FQ_AW-1:0] r_wr, n_wr;
    logic [kit_pkg::FQ_AW-1:0] r_rd, n_rd;
    logic [kit_pkg::FQ_AW:0]   r_cnt, n_cnt;

    kit_pkg::t_item w_item;
    logic           w_push;
    logic           w_alpha;
    logic [7:0]     w_b;

    // character classes
    always_comb begin
        w_b     = i_s_axis_tdata;
        w_alpha = ((w_b >= "A") && (w_b <= "Z")) || ((w_b >= "a") && (w_b <= "z"));
        w_item.data     = w_b;
        w_item.eof      = i_s_axis_tuser;
        w_item.blank    = (w_b == kit_pkg::CH_SPACE) || (w_b == kit_pkg::CH_TAB);
        w_item.newline  = (w_b == kit_pkg::CH_NL);
        w_item.hash     = (w_b == kit_pkg::CH_HASH);
        w_item.quote    = (w_b == kit_pkg::CH_QUOTE);
        w_item.space    = (w_b == kit_pkg::CH_SPACE) ||
                          ((w_b >= kit_pkg::CH_TAB) && (w_b <= kit_pkg::CH_CR));
        w_item.digit    = (w_b >= "0") && (w_b <= "9");
        w_item.id_start = w_alpha || (w_b == "_");
        w_item.id_cont  = w_alpha || w_item.digit || (w_b == kit_pkg::CH_NUL) ||
                          (w_b == "_") || (w_b == ".") || (w_b == "*") ||
                          (w_b == "[") || (w_b == "]") || (w_b == "<") || (w_b == ">");
    end

    assign o_s_axis_tready = (r_cnt < (kit_pkg::FQ_AW + 1)'(kit_pkg::FQ_DEPTH));
    assign w_push          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_q_valid       = (r_cnt != '0);
    assign o_q_item        = r_slot[r_rd];

    always_comb begin
        n_wr  = r_wr + (kit_pkg::FQ_AW)'(w_push);
        n_rd  = r_rd + (kit_pkg::FQ_AW)'(i_q_pop);
        n_cnt = r_cnt + (kit_pkg::FQ_AW + 1)'(w_push) - (kit_pkg::FQ_AW + 1)'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= w_item;
        end
    end

endmodule

>>> rtl/kit_back.sv
// ---------------------------------------------------------------------------
// kit_back
// lexer: one classified byte per cycle, given room, into zero to two results
// ---------------------------------------------------------------------------
`include "keyword_identifier_tokenizer_top_defines.svh"

module kit_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  kit_pkg::t_item i_item,
    output logic           o_q_pop,
    input  logic           i_room,
    output kit_pkg::t_push o_push
);

    kit_pkg::t_mode                 r_mode, n_mode;
    logic [kit_pkg::LINE_BITS-1:0]  r_line, n_line;
    logic [kit_pkg::LEN_W-1:0]      r_len,  n_len;
    logic [kit_pkg::NKW-1:0]        r_cand, n_cand;
    logic [kit_pkg::FCNT_W-1:0]     r_fcnt, n_fcnt;

    logic             w_accept;
    logic             w_start;
    logic [1:0]       w_cnt;
    kit_pkg::t_result w_res0, w_res1, w_tok, w_name_tok;

    assign w_accept = i_q_valid && i_room;
    assign o_q_pop  = w_accept;

    // name token of the open identifier
    always_comb begin
        w_name_tok       = '0;
        w_name_tok.kind  = kit_pkg::kw_finish(r_cand, r_len, r_mode == kit_pkg::M_IDENT_NUL);
        w_name_tok.line  = r_line;
        w_name_tok.len   = r_len;
    end

    always_comb begin
        n_mode  = r_mode;
        n_line  = r_line;
        n_len   = r_len;
        n_cand  = r_cand;
        n_fcnt  = r_fcnt;
        w_res0  = '0;
        w_res1  = '0;
        w_tok   = '0;
        w_cnt   = 2'd0;
        w_start = 1'b0;

        if (i_item.eof) begin
            if ((r_mode == kit_pkg::M_IDENT) || (r_mode == kit_pkg::M_IDENT_NUL)) begin
                w_res0 = w_name_tok;
                w_cnt  = 2'd1;
                n_len  = '0;
            end else if (r_mode == kit_pkg::M_HASH_SP) begin
                n_line = '0;
            end
            n_mode     = kit_pkg::M_START;
            n_fcnt     = '0;
            w_tok.kind = kit_pkg::K_END;
            w_tok.line = n_line;
            if (w_cnt == 2'd0) begin
                w_res0 = w_tok;
            end else begin
                w_res1 = w_tok;
            end
            w_cnt = w_cnt + 2'd1;
        end else begin
            unique case (r_mode)
                kit_pkg::M_IDENT, kit_pkg::M_IDENT_NUL: begin
                    if (i_item.id_cont && (r_len < kit_pkg::LEN_W'(kit_pkg::MAX_NAME))) begin
                        if (r_mode == kit_pkg::M_IDENT) begin
                            if (i_item.data == kit_pkg::CH_NUL) begin
                                n_cand = kit_pkg::kw_trim(r_cand, r_len);
                                n_mode = kit_pkg::M_IDENT_NUL;
                            end else begin
                                n_cand = kit_pkg::kw_narrow(r_cand, r_len, i_item.data);
                            end
                        end
                        n_len        = r_len + kit_pkg::LEN_W'(1);
                        w_res0.kind  = kit_pkg::K_NAME_BYTE;
                        w_res0.value = i_item.data;
                        w_res0.line  = r_line;
                        w_cnt        = 2'd1;
                    end else begin
                        // name ends, the byte is handled again from start
                        w_res0  = w_name_tok;
                        w_cnt   = 2'd1;
                        n_mode  = kit_pkg::M_START;
                        n_len   = '0;
                        w_start = 1'b1;
                    end
                end
                kit_pkg::M_HASH_SP: begin
                    if (!i_item.space) begin
                        if (i_item.digit) begin
                            n_line = kit_pkg::LINE_BITS'(i_item.data[3:0]);
                            n_mode = kit_pkg::M_HASH_DIG;
                        end else begin
                            n_line = '0;
                            n_mode = kit_pkg::M_SEEK_Q;
                        end
                    end
                end
                kit_pkg::M_HASH_DIG: begin
                    if (i_item.digit) begin
                        n_line = (r_line << 3) + (r_line << 1) +
                                 kit_pkg::LINE_BITS'(i_item.data[3:0]);
                    end else begin
                        n_mode = kit_pkg::M_SEEK_Q;
                    end
                end
                kit_pkg::M_SEEK_Q: begin
                    if (i_item.quote) begin
                        n_fcnt = '0;
                        n_mode = kit_pkg::M_FNAME;
                    end
                end
                kit_pkg::M_FNAME: begin
                    if (i_item.quote ||
                        (r_fcnt >= kit_pkg::FCNT_W'(kit_pkg::MAX_FILE_NAME))) begin
                        n_mode = kit_pkg::M_SKIP_EOL;
                    end else begin
                        n_fcnt = r_fcnt + kit_pkg::FCNT_W'(1);
                    end
                end
                kit_pkg::M_SKIP_EOL: begin
                    if (i_item.newline) begin
                        n_mode = kit_pkg::M_START;
                    end
                end
                kit_pkg::M_START: begin
                    w_start = 1'b1;
                end
            endcase

            if (w_start) begin
                priority if (i_item.blank) begin
                    // skipped
                end else if (i_item.newline) begin
                    n_line = n_line + kit_pkg::LINE_BITS'(1);
                end else if (i_item.hash) begin
                    n_mode = kit_pkg::M_HASH_SP;
                end else if (i_item.id_start) begin
                    n_mode      = kit_pkg::M_IDENT;
                    n_cand      = kit_pkg::kw_narrow(kit_pkg::ALL_KW, '0, i_item.data);
                    n_len       = kit_pkg::LEN_W'(1);
                    w_tok.kind  = kit_pkg::K_NAME_BYTE;
                    w_tok.value = i_item.data;
                    w_tok.line  = n_line;
                    if (w_cnt == 2'd0) begin
                        w_res0 = w_tok;
                    end else begin
                        w_res1 = w_tok;
                    end
                    w_cnt = w_cnt + 2'd1;
                end else begin
                    w_tok.kind  = kit_pkg::K_CHAR;
                    w_tok.value = i_item.data;
                    w_tok.line  = n_line;
                    if (w_cnt == 2'd0) begin
                        w_res0 = w_tok;
                    end else begin
                        w_res1 = w_tok;
                    end
                    w_cnt = w_cnt + 2'd1;
                end
            end
        end

        // mark the final result of this byte
        if (w_cnt == 2'd1) begin
            w_res0.last = 1'b1;
        end else if (w_cnt == 2'd2) begin
            w_res1.last = 1'b1;
        end
    end

    always_comb begin
        o_push.count  = w_accept ? w_cnt : 2'd0;
        o_push.first  = w_res0;
        o_push.second = w_res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= kit_pkg::M_START;
            r_line <= '0;
            r_len  <= '0;
            r_cand <= kit_pkg::ALL_KW;
            r_fcnt <= '0;
        end else if (w_accept) begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_len  <= n_len;
            r_cand <= n_cand;
            r_fcnt <= n_fcnt;
        end
    end

    `KIT_ASSERT_IMPL(a_no_len_outside_name, i_clk, i_rst_n, (r_mode == kit_pkg::M_START) || (r_mode == kit_pkg::M_HASH_SP), r_len == '0)
    `KIT_ASSERT_IMPL(a_len_bounded, i_clk, i_rst_n, r_mode != kit_pkg::M_START, r_len <= kit_pkg::LEN_W'(kit_pkg::MAX_NAME))
    `KIT_ASSERT_IMPL(a_fcnt_bounded, i_clk, i_rst_n, r_mode == kit_pkg::M_FNAME, r_fcnt <= kit_pkg::FCNT_W'(kit_pkg::MAX_FILE_NAME))
    `KIT_ASSERT_NEXT(a_end_returns_start, i_clk, i_rst_n, w_accept && i_item.eof, (r_mode == kit_pkg::M_START) && (r_len == '0))

endmodule

>>> rtl/kit_rq.sv
// ---------------------------------------------------------------------------
// kit_rq
// result queue: takes up to two results a cycle, while tready is high sends one a cycle
// ---------------------------------------------------------------------------
module kit_rq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  kit_pkg::t_push              i_push,
    output logic                        o_room,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [kit_pkg::TDATA_W-1:0] o_m_axis_tdata,   // token_value, line_number, name_length
    output logic [3:0]                  o_m_axis_tuser,   // token_kind
    output logic                        o_m_axis_tlast    // last
);

    kit_pkg::t_result          r_mem [kit_pkg::RQ_DEPTH];
    logic [kit_pkg::RQ_AW-1:0] r_wr, n_wr;
    logic [kit_pkg::RQ_AW-1:0] r_rd, n_rd;
    logic [kit_pkg::RQ_AW:0]   r_cnt, n_cnt;

    logic             w_pop;
    kit_pkg::t_result w_head;

    // room for a byte that makes two results
    assign o_room = (r_cnt <= (kit_pkg::RQ_AW + 1)'(kit_pkg::RQ_DEPTH - 2));
    assign w_pop  = o_m_axis_tvalid && i_m_axis_tready;
    assign w_head = r_mem[r_rd];

    assign o_m_axis_tvalid = (r_cnt != '0);
    assign o_m_axis_tdata  = {{kit_pkg::OUT_PAD{1'b0}}, w_head.len, w_head.line, w_head.value};
    assign o_m_axis_tuser  = w_head.kind;
    assign o_m_axis_tlast  = w_head.last;

    always_comb begin
        n_wr  = r_wr + (kit_pkg::RQ_AW)'(i_push.count);
        n_rd  = r_rd + (kit_pkg::RQ_AW)'(w_pop);
        n_cnt = r_cnt + (kit_pkg::RQ_AW + 1)'(i_push.count) - (kit_pkg::RQ_AW + 1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + (kit_pkg::RQ_AW)'(1)] <= i_push.second;
        end
    end

endmodule

>>> rtl/keyword_identifier_tokenizer_top.sv
// ---------------------------------------------------------------------------
// keyword_identifier_tokenizer_top
// byte stream tokenizer for names, keywords, char tokens and line directives
// ---------------------------------------------------------------------------
// The block takes one byte (or an end marker, tuser high) per cycle on the
// slave side while its input queue has room, and gives one token per cycle
// on the master side while tready is high. Blanks and tabs vanish, newlines
// bump the line count, names are echoed byte by byte and closed by a name
// or keyword token, '#' lines reload the line count. A byte that closes a
// name and also makes a token of its own, and an end marker that closes a
// name, give two tokens; the lexer takes a byte only while the result queue
// has room for two results. An accepted byte is registered in the input
// queue; the lexer reads it there and writes its tokens into the result
// queue, which drives the master side.
// No clearing pass after reset; the block is ready as soon as reset drops.
// ---------------------------------------------------------------------------
module keyword_identifier_tokenizer_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // slave side
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,   // [7:0] data_byte
    input  logic                        i_s_axis_tuser,   // [0] end_of_input
    // master side
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [kit_pkg::TDATA_W-1:0] o_m_axis_tdata,   // [7:0] token_value,
                                                          // [27:8] line_number,
                                                          // [37:28] name_length
    output logic [3:0]                  o_m_axis_tuser,   // [3:0] token_kind
    output logic                        o_m_axis_tlast    // last result of a byte
);

    // front to back: classified bytes
    logic           w_q_valid;
    logic           w_q_pop;
    kit_pkg::t_item w_q_item;

    // back to result queue
    logic           w_room;
    kit_pkg::t_push w_push;

    // classify and buffer incoming transfers
    kit_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_q_valid       (w_q_valid),
        .o_q_item        (w_q_item),
        .i_q_pop         (w_q_pop)
    );

    // lexer state, one byte per cycle while the result queue has room
    kit_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_item    (w_q_item),
        .o_q_pop   (w_q_pop),
        .i_room    (w_room),
        .o_push    (w_push)
    );

    // results wait here until the master side takes the transfer
    kit_rq u_rq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (w_push),
        .o_room          (w_room),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

>>> sim/keyword_identifier_tokenizer_top_tb.sv
// ---------------------------------------------------------------------------
// keyword_identifier_tokenizer_top_tb
// self-checking bench for the byte stream tokenizer
// ---------------------------------------------------------------------------
// Bytes and end markers go in on the slave stream. A lexer model inside the
// bench follows every accepted transfer and queues the tokens it should give.
// Each master stream transfer is checked against the oldest queued token.
// Directed sequences cover single bytes, keywords, nul inside a name, end
// markers and line directives. Names and file names at their size limits
// come next. Random token-shaped traffic runs under several idle patterns
// and one long receiver hold-off.
// ---------------------------------------------------------------------------
module keyword_identifier_tokenizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kit_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 16;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        t_kind                kind;
        logic [7:0]           value;
        logic [LINE_BITS-1:0] line;
        logic [LEN_W-1:0]     len;
        logic                 last;
    } t_token;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [7:0]           i_s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic                 i_s_axis_tuser = 1'b0;    // [0] end_of_input
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   o_m_axis_tdata;           // [7:0] value, [27:8] line,
                                                    // [37:28] length
    logic [3:0]           o_m_axis_tuser;           // [3:0] token_kind
    logic                 o_m_axis_tlast;

    keyword_identifier_tokenizer_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // keyword spelling and the token kind each one maps to, in priority order
    string kw_word [NKW] = '{"INORDER", "OUTORDER", "NAME", "ONE", "ZERO"};
    t_kind kw_kind [NKW] = '{K_INORDER, K_OUTORDER, K_PLANAME, K_ONE, K_ZERO};

    string name_head = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_";
    string name_tail = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_0123456789.*[]<>";
    string punct     = "!\"#$%&'()+,-/:;=?@\\^`{|}~";

    // lexer model state
    t_mode                lx_mode;
    logic [LINE_BITS-1:0] lx_line;
    logic [LEN_W-1:0]     lx_len;
    logic [NKW-1:0]       lx_cand;
    logic [FCNT_W-1:0]    lx_fcount;

    t_token pending_tokens [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_cnt    = 0;
    int bytes_sent  = 0;
    int mismatches  = 0;
    int cycle_count = 0;

    // ------------------------------------------------------------------
    // lexer model
    // ------------------------------------------------------------------
    task automatic reset_lexer();
        lx_mode   = M_START;
        lx_line   = '0;
        lx_len    = '0;
        lx_cand   = ALL_KW;
        lx_fcount = '0;
    endtask

    function automatic bit is_letter(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic bit is_num(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit in_name(input logic [7:0] b);
        return is_letter(b) || is_num(b) || b == CH_NUL || b == "_" || b == "." ||
               b == "*" || b == "[" || b == "]" || b == "<" || b == ">";
    endfunction

    task automatic add_token(input t_kind kind, input logic [7:0] value,
                             input logic [LEN_W-1:0] len);
        t_token t;
        t.kind  = kind;
        t.value = value;
        t.line  = lx_line;
        t.len   = len;
        t.last  = 1'b0;
        pending_tokens.push_back(t);
    endtask

    // drop keywords that do not have this byte at this position
    task automatic match_keywords(input int pos, input logic [7:0] b);
        for (int k = 0; k < NKW; k++) begin
            if (pos >= kw_word[k].len() || kw_word[k][pos] != b)
                lx_cand[k] = 1'b0;
        end
    endtask

    task automatic close_name();
        t_kind kind;
        bit    found;
        kind  = K_NAME;
        found = 1'b0;
        for (int k = 0; k < NKW; k++) begin
            // after a nul the candidates were already cut to the right length
            if (!found && lx_cand[k] &&
                (lx_mode == M_IDENT_NUL || kw_word[k].len() == lx_len)) begin
                kind  = kw_kind[k];
                found = 1'b1;
            end
        end
        add_token(kind, 8'h00, lx_len);
        lx_mode = M_START;
        lx_len  = '0;
    endtask

    task automatic lex_fresh_byte(input logic [7:0] b);
        if (b == CH_SPACE || b == CH_TAB) begin
            // blanks vanish
        end else if (b == CH_NL) begin
            lx_line = lx_line + 1'b1;
        end else if (b == CH_HASH) begin
            lx_mode = M_HASH_SP;
        end else if (is_letter(b) || b == "_") begin
            lx_mode = M_IDENT;
            lx_cand = ALL_KW;
            match_keywords(0, b);
            lx_len = 1;
            add_token(K_NAME_BYTE, b, '0);
        end else begin
            add_token(K_CHAR, b, '0);
        end
    endtask

    // advance the model by one accepted transfer and queue its tokens
    task automatic predict_tokens(input logic [7:0] b, input logic eoi);
        int          prior_size;
        t_token      t;
        logic [31:0] wide;
        prior_size = pending_tokens.size();
        if (eoi) begin
            if (lx_mode == M_IDENT || lx_mode == M_IDENT_NUL)
                close_name();
            else if (lx_mode == M_HASH_SP)
                lx_line = '0;
            lx_mode   = M_START;
            lx_fcount = '0;
            add_token(K_END, 8'h00, '0);
        end else begin
            case (lx_mode)
                M_IDENT, M_IDENT_NUL: begin
                    if (in_name(b) && lx_len < MAX_NAME) begin
                        if (lx_mode == M_IDENT) begin
                            if (b == CH_NUL) begin
                                // only the part before the nul picks the keyword
                                for (int k = 0; k < NKW; k++)
                                    if (kw_word[k].len() != lx_len) lx_cand[k] = 1'b0;
                                lx_mode = M_IDENT_NUL;
                            end else begin
                                match_keywords(lx_len, b);
                            end
                        end
                        lx_len = lx_len + 1'b1;
                        add_token(K_NAME_BYTE, b, '0);
                    end else begin
                        close_name();
                        lex_fresh_byte(b);
                    end
                end
                M_HASH_SP: begin
                    if (!(b == CH_SPACE || (b >= 8'd9 && b <= 8'd13))) begin
                        if (is_num(b)) begin
                            lx_line = LINE_BITS'(b - "0");
                            lx_mode = M_HASH_DIG;
                        end else begin
                            lx_line = '0;
                            lx_mode = M_SEEK_Q;
                        end
                    end
                end
                M_HASH_DIG: begin
                    if (is_num(b)) begin
                        wide    = 32'(lx_line) * 32'd10 + 32'(b - "0");
                        lx_line = wide[LINE_BITS-1:0];
                    end else begin
                        lx_mode = M_SEEK_Q;
                    end
                end
                M_SEEK_Q: begin
                    if (b == CH_QUOTE) begin
                        lx_fcount = '0;
                        lx_mode   = M_FNAME;
                    end
                end
                M_FNAME: begin
                    if (b == CH_QUOTE || lx_fcount >= MAX_FILE_NAME)
                        lx_mode = M_SKIP_EOL;
                    else
                        lx_fcount = lx_fcount + 1'b1;
                end
                M_SKIP_EOL: begin
                    if (b == CH_NL) lx_mode = M_START;
                end
                default: lex_fresh_byte(b);
            endcase
        end
        if (pending_tokens.size() > prior_size) begin
            t = pending_tokens.pop_back();
            t.last = 1'b1;
            pending_tokens.push_back(t);
        end
    endtask

    // ------------------------------------------------------------------
    // slave side driver
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic eoi);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= eoi;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        bytes_sent++;
        predict_tokens(b, eoi);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_byte(8'($urandom_range(255)), 1'b1);
    endtask

    // stop offering, then wait until every queued token has come out
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    function automatic logic [7:0] any_space();
        return $urandom_range(1) ? CH_SPACE : 8'($urandom_range(9, 13));
    endfunction

    // ------------------------------------------------------------------
    // random token-shaped stimulus
    // ------------------------------------------------------------------
    task automatic send_random_name();
        int form;
        int k;
        int n;
        form = $urandom_range(5);
        k    = $urandom_range(NKW - 1);
        case (form)
            0: send_text(kw_word[k]);
            1: begin
                // keyword with one byte too many
                send_text(kw_word[k]);
                send_byte(pick(name_tail), 1'b0);
            end
            2: send_text(kw_word[k].substr(0, $urandom_range(kw_word[k].len() - 2)));
            3: begin
                // nul after a keyword or after part of one
                send_text(kw_word[k].substr(0, $urandom_range(kw_word[k].len() - 1)));
                send_byte(CH_NUL, 1'b0);
                send_byte(pick(name_tail), 1'b0);
            end
            default: begin
                send_byte(pick(name_head), 1'b0);
                n = $urandom_range(9);
                repeat (n)
                    send_byte(($urandom_range(15) == 0) ? CH_NUL : pick(name_tail), 1'b0);
            end
        endcase
    endtask

    task automatic send_random_directive(input bit well_formed);
        int n;
        send_byte(CH_HASH, 1'b0);
        n = $urandom_range(2);
        repeat (n) send_byte(any_space(), 1'b0);
        // long digit runs can make the line count wrap
        n = ($urandom_range(7) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 3);
        repeat (n) send_byte(8'("0" + $urandom_range(9)), 1'b0);
        if (!well_formed) begin
            n = $urandom_range(6);
            repeat (n) send_byte(($urandom_range(3) == 0) ? CH_NL : 8'($urandom_range(255)), 1'b0);
            if ($urandom_range(1)) send_end();
        end else begin
            send_byte($urandom_range(3) == 0 ? pick(punct) : CH_SPACE, 1'b0);
            n = $urandom_range(2);
            repeat (n) send_byte(CH_SPACE, 1'b0);
            send_byte(CH_QUOTE, 1'b0);
            n = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(8);
            repeat (n) send_byte(pick(name_tail), 1'b0);
            send_byte(CH_QUOTE, 1'b0);
            n = $urandom_range(2);
            repeat (n) send_byte(pick(name_head), 1'b0);
            send_byte(CH_NL, 1'b0);
        end
    endtask

    task automatic send_random_unit();
        int r;
        r = $urandom_range(99);
        if (r < 30)       send_random_name();
        else if (r < 42)  send_byte(pick(" \t\n"), 1'b0);
        else if (r < 46)  send_byte(8'($urandom_range(9, 13)), 1'b0);
        else if (r < 58)  send_byte(pick(punct), 1'b0);
        else if (r < 70)  send_byte(8'($urandom_range(255)), 1'b0);
        else if (r < 84)  send_random_directive(1'b1);
        else if (r < 92)  send_random_directive(1'b0);
        else              send_end();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // single bytes, high bytes, nul inside a name, blanks and an end marker
    task automatic test_bytes_and_names();
        send_text("ONE");
        send_byte(CH_NUL, 1'b0);
        send_byte("q", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_byte("_", 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();
    endtask

    // directive reloads the line to its maximum, the newline after the directive's own one wraps it
    task automatic test_directives();
        send_byte(CH_HASH, 1'b0);
        send_end();
        send_text("#1048575 \"f\"\n\nZ");
        send_end();
        drain();
    endtask

    // a full name and a full file name
    task automatic test_size_limits();
        send_byte(pick(name_head), 1'b0);
        repeat (MAX_NAME - 1) send_byte(pick(name_tail), 1'b0);
        send_byte("A", 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_text("#5 \"");
        repeat (MAX_FILE_NAME) send_byte("a", 1'b0);
        send_text("\"x\nB");
        send_end();
        drain();
    endtask

    task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
        int stop_at;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at     = bytes_sent + count;
        while (bytes_sent < stop_at) send_random_unit();
        drain();
    endtask

    // receiver stops for a long stretch while bytes keep coming
    task automatic test_backpressure();
        int stop_at;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req++;
        stop_at = bytes_sent + 80;
        while (bytes_sent < stop_at) send_random_unit();
        drain();
    endtask

    // ------------------------------------------------------------------
    // master side ready, with random stalls and requested hold-offs
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen       <= hold_req;
            hold_cnt        <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt        <= hold_cnt - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // token checker
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        t_token               want;
        logic [7:0]           got_value;
        logic [LINE_BITS-1:0] got_line;
        logic [LEN_W-1:0]     got_len;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_value = o_m_axis_tdata[7:0];
            got_line  = o_m_axis_tdata[8 +: LINE_BITS];
            got_len   = o_m_axis_tdata[8 + LINE_BITS +: LEN_W];
            if (pending_tokens.size() == 0) begin
                note_mismatch($sformatf("token with none expected: kind %0d value %02h",
                                        o_m_axis_tuser, got_value));
            end else begin
                want = pending_tokens.pop_front();
                if (o_m_axis_tuser !== want.kind || got_value !== want.value ||
                    got_line !== want.line || got_len !== want.len ||
                    o_m_axis_tlast !== want.last) begin
                    note_mismatch($sformatf({"expected kind %0d value %02h line %0d ",
                                             "len %0d last %0b, got kind %0d value %02h ",
                                             "line %0d len %0d last %0b"},
                                            want.kind, want.value, want.line, want.len,
                                            want.last, o_m_axis_tuser, got_value, got_line,
                                            got_len, o_m_axis_tlast));
                end
            end
        end
    end

    // run time guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("keyword_identifier_tokenizer_top test failed");
            $finish;
        end
    end

    initial begin
        reset_lexer();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_bytes_and_names();
        test_directives();
        test_size_limits();
        test_random_traffic(280, 7, 84);
        test_random_traffic(280, 84, 7);
        test_backpressure();
        test_random_traffic(280, 0, 0);

        if (mismatches == 0 && pending_tokens.size() == 0)
            $display("keyword_identifier_tokenizer_top test passed");
        else
            $display("keyword_identifier_tokenizer_top test failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/kit_pkg.sv
rtl/kit_front.sv
rtl/kit_back.sv
rtl/kit_rq.sv
rtl/keyword_identifier_tokenizer_top.sv
sim/keyword_identifier_tokenizer_top_tb.sv
